@@ hw/rtl/pfi_pkg.sv @@
// Shared types, codes and constants of the partial frame interpolator.
`timescale 1ns / 1ps
package pfi_pkg;

    localparam int DEF_MAX_PARTIALS = 64;
    localparam int DEF_MAX_FRAMES   = 256;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_INTERP  = 2'd1;
    localparam logic [1:0] OP_NEAREST = 2'd2;
    localparam logic [1:0] OP_INDEX   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_PART  = 2'd1;
    localparam logic [1:0] ST_BAD_RANGE = 2'd2;

    typedef struct packed {
        logic signed [15:0] phase;
        logic [15:0]        bw;
        logic [31:0]        freq;
        logic [15:0]        amp;
        logic [31:0]        ftime;
    } frame_t;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quo;
    } div_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_RD2,
        S_RD3,
        S_EVAL,
        S_DIV,
        S_MULA,
        S_MULB,
        S_SUM,
        S_IDX,
        S_DONE
    } state_t;

endpackage

@@ hw/rtl/partial_frame_interpolator.sv @@
// Top level of the partial frame interpolator: control sequencer and datapath.
`timescale 1ns / 1ps
// One item at a time, from the accepting edge to the edge that raises m_tvalid.
// A frame write or a rejected query passes S_CHECK and S_DONE; an index query
// adds S_IDX. A time query scans the partial's stored frame times through the
// single read port of the frame RAM, one time per cycle. A nearest query then
// reads both bracketing frames and picks one in S_IDX. An interpolated query
// reads them, waits on the 16-step divider when the fraction needs it, and then
// runs S_MULA, S_MULB and S_SUM for amplitude, frequency and bandwidth in turn.
// A new item is taken while a result waits at the output register. No clearing
// pass follows reset.
module partial_frame_interpolator
    import pfi_pkg::*;
#(
    parameter int MAX_PARTIALS = DEF_MAX_PARTIALS,
    parameter int MAX_FRAMES   = DEF_MAX_FRAMES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [6:0]   cfg_wr_data,   // partials_in_use
    input  logic         s_tvalid,
    output logic         s_tready,
    // op[1:0] partial_index[7:2] frame_index[15:8] query_time[47:16]
    // in_amp[63:48] in_freq[95:64] in_bandwidth[111:96] in_phase[127:112]
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0] out_amp[17:2] out_freq[49:18] out_bandwidth[65:50]
    // out_phase[81:66], zero fill above
    output logic [87:0]  m_tdata
);
    localparam int DEPTH = MAX_PARTIALS * MAX_FRAMES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_FRAMES + 1);
    localparam int PAW   = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;

    state_t state_reg, state_next;
    logic [6:0] piu_reg;

    logic [1:0]  op_reg;
    logic [5:0]  p_reg;
    logic [7:0]  f_reg;
    logic [31:0] t_reg;
    frame_t      win_reg;

    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] chk_reg, chk_next;
    logic          chkv_reg, chkv_next;
    logic [CW-1:0] lim_reg, lim_next;
    logic [CW-1:0] i2_reg, i2_next;
    frame_t        f1_reg, f1_next, f2_reg, f2_next;
    logic [16:0]   frac_reg, frac_next;
    logic [1:0]    k_reg, k_next;
    logic [48:0]   pa_reg, pa_next, pb_reg, pb_next;

    logic [1:0]  rstat_reg, rstat_next;
    logic [15:0] ramp_reg, ramp_next;
    logic [31:0] rfreq_reg, rfreq_next;
    logic [15:0] rbw_reg, rbw_next;
    logic [15:0] rph_reg, rph_next;

    logic        mv_reg, mv_next;
    logic [81:0] md_reg, md_next;

    logic          fm_we;
    logic [AW-1:0] fm_waddr, fm_raddr, base;
    frame_t        fm_wdata, fm_rdata;

    logic           pm_we;
    logic [PAW-1:0] pm_addr, pm_raddr;
    logic [CW-1:0]  pm_wcnt, pm_rcnt;
    logic [31:0]    pm_wmin, pm_wmax, pm_rmin, pm_rmax;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [31:0] lane_a, lane_b;
    logic [49:0] lsum;
    logic signed [32:0] d1, d2;
    logic        accept;
    logic        p_ok_wr;
    logic        f_ok_wr;

    pfi_frame_mem #(.DEPTH(DEPTH), .AW(AW)) u_frame_mem (
        .clk  (clk),
        .we   (fm_we),
        .waddr(fm_waddr),
        .wdata(fm_wdata),
        .raddr(fm_raddr),
        .rdata(fm_rdata)
    );

    pfi_part_mem #(.MAX_PARTIALS(MAX_PARTIALS), .CW(CW), .PAW(PAW)) u_part_mem (
        .clk  (clk),
        .rst_n(rst_n),
        .we   (pm_we),
        .waddr(pm_addr),
        .wcnt (pm_wcnt),
        .wmin (pm_wmin),
        .wmax (pm_wmax),
        .raddr(pm_raddr),
        .rcnt (pm_rcnt),
        .rmin (pm_rmin),
        .rmax (pm_rmax)
    );

    pfi_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = {6'b0, md_reg};

    assign base    = AW'(AW'(p_reg) * AW'(MAX_FRAMES));
    assign pm_addr = PAW'(p_reg);
    assign pm_raddr = accept ? PAW'(s_tdata[7:2]) : pm_addr;
    assign p_ok_wr = 32'(p_reg) < MAX_PARTIALS;
    assign f_ok_wr = 32'(f_reg) < MAX_FRAMES;

    assign fm_waddr = AW'(base + AW'(f_reg));
    assign fm_wdata = win_reg;
    assign pm_wcnt  = (32'(pm_rcnt) < 32'(f_reg) + 32'd1) ? CW'(32'(f_reg) + 32'd1) : pm_rcnt;
    assign pm_wmin  = (t_reg < pm_rmin) ? t_reg : pm_rmin;
    assign pm_wmax  = (t_reg > pm_rmax) ? t_reg : pm_rmax;

    assign d1 = $signed({1'b0, t_reg}) - $signed({1'b0, f1_reg.ftime});
    assign d2 = $signed({1'b0, f2_reg.ftime}) - $signed({1'b0, t_reg});

    always_comb
    begin
        case (k_reg)
            2'd0:    begin lane_a = {16'b0, f1_reg.amp}; lane_b = {16'b0, f2_reg.amp}; end
            2'd1:    begin lane_a = f1_reg.freq; lane_b = f2_reg.freq; end
            default: begin lane_a = {16'b0, f1_reg.bw}; lane_b = {16'b0, f2_reg.bw}; end
        endcase
    end

    assign lsum = {1'b0, pa_reg} + {1'b0, pb_reg} + 50'd32768;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        chk_next   = chk_reg;
        chkv_next  = chkv_reg;
        lim_next   = lim_reg;
        i2_next    = i2_reg;
        f1_next    = f1_reg;
        f2_next    = f2_reg;
        frac_next  = frac_reg;
        k_next     = k_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        rstat_next = rstat_reg;
        ramp_next  = ramp_reg;
        rfreq_next = rfreq_reg;
        rbw_next   = rbw_reg;
        rph_next   = rph_reg;
        mv_next    = mv_reg;
        md_next    = md_reg;
        fm_we      = 1'b0;
        pm_we      = 1'b0;
        fm_raddr   = AW'(base + AW'(idx_reg));
        div_req    = '{start: 1'b0, num: t_reg - f1_reg.ftime,
                       den: f2_reg.ftime - f1_reg.ftime};

        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                rstat_next = ST_OK;
                ramp_next  = '0;
                rfreq_next = '0;
                rbw_next   = '0;
                rph_next   = '0;
                state_next = S_DONE;
                if (op_reg == OP_WRITE)
                begin
                    if (!p_ok_wr)
                    begin
                        rstat_next = ST_BAD_PART;
                    end
                    else if (!f_ok_wr)
                    begin
                        rstat_next = ST_BAD_RANGE;
                    end
                    else
                    begin
                        fm_we = 1'b1;
                        pm_we = 1'b1;
                    end
                end
                else if (!p_ok_wr || ({1'b0, p_reg} >= piu_reg))
                begin
                    rstat_next = ST_BAD_PART;
                end
                else if (op_reg == OP_INDEX)
                begin
                    if (!f_ok_wr || (32'(f_reg) >= 32'(pm_rcnt)))
                    begin
                        rstat_next = ST_BAD_RANGE;
                    end
                    else
                    begin
                        fm_raddr   = AW'(base + AW'(f_reg));
                        state_next = S_IDX;
                    end
                end
                else if (!(t_reg >= pm_rmin && t_reg < pm_rmax))
                begin
                    rstat_next = ST_BAD_RANGE;
                end
                else
                begin
                    lim_next   = pm_rcnt;
                    idx_next   = CW'(1);
                    chkv_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (chkv_reg && (t_reg < fm_rdata.ftime))
                begin
                    i2_next    = chk_reg;
                    fm_raddr   = AW'(base + AW'(chk_reg - CW'(1)));
                    state_next = S_RD2;
                end
                else if (idx_reg < lim_reg)
                begin
                    chk_next  = idx_reg;
                    chkv_next = 1'b1;
                    idx_next  = idx_reg + CW'(1);
                end
                else
                begin
                    i2_next    = CW'(1);
                    fm_raddr   = base;
                    state_next = S_RD2;
                end
            end
            S_RD2:
            begin
                f1_next    = fm_rdata;
                fm_raddr   = AW'(base + AW'(i2_reg));
                state_next = S_RD3;
            end
            S_RD3:
            begin
                f2_next    = fm_rdata;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (op_reg == OP_NEAREST)
                begin
                    state_next = S_IDX;
                end
                else
                begin
                    k_next = 2'd0;
                    if (f2_reg.ftime <= f1_reg.ftime || t_reg <= f1_reg.ftime)
                    begin
                        frac_next  = 17'd0;
                        state_next = S_MULA;
                    end
                    else if (t_reg >= f2_reg.ftime)
                    begin
                        frac_next  = 17'd65536;
                        state_next = S_MULA;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    frac_next  = {1'b0, div_rsp.quo};
                    state_next = S_MULA;
                end
            end
            S_MULA:
            begin
                pa_next    = lane_a * (17'd65536 - frac_reg);
                state_next = S_MULB;
            end
            S_MULB:
            begin
                pb_next    = lane_b * frac_reg;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                case (k_reg)
                    2'd0:    ramp_next  = lsum[31:16];
                    2'd1:    rfreq_next = lsum[47:16];
                    default: rbw_next   = lsum[31:16];
                endcase
                if (k_reg == 2'd2)
                begin
                    rph_next   = f1_reg.phase;
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_MULA;
                end
            end
            S_IDX:
            begin
                // index query: RAM data; nearest query: pick from f1/f2
                if (op_reg == OP_INDEX)
                begin
                    ramp_next  = fm_rdata.amp;
                    rfreq_next = fm_rdata.freq;
                    rbw_next   = fm_rdata.bw;
                    rph_next   = fm_rdata.phase;
                end
                else if (d1 < d2)
                begin
                    ramp_next  = f1_reg.amp;
                    rfreq_next = f1_reg.freq;
                    rbw_next   = f1_reg.bw;
                    rph_next   = f1_reg.phase;
                end
                else
                begin
                    ramp_next  = f2_reg.amp;
                    rfreq_next = f2_reg.freq;
                    rbw_next   = f2_reg.bw;
                    rph_next   = f2_reg.phase;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    md_next    = {rph_reg, rbw_reg, rfreq_reg, ramp_reg, rstat_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            piu_reg   <= '0;
            mv_reg    <= 1'b0;
            chkv_reg  <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            chkv_reg  <= chkv_next;
            k_reg     <= k_next;
            if (cfg_wr_en)
            begin
                piu_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= s_tdata[1:0];
            p_reg   <= s_tdata[7:2];
            f_reg   <= s_tdata[15:8];
            t_reg   <= s_tdata[47:16];
            win_reg <= '{phase: s_tdata[127:112], bw: s_tdata[111:96],
                         freq: s_tdata[95:64], amp: s_tdata[63:48],
                         ftime: s_tdata[47:16]};
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        chk_reg   <= chk_next;
        lim_reg   <= lim_next;
        i2_reg    <= i2_next;
        f1_reg    <= f1_next;
        f2_reg    <= f2_next;
        frac_reg  <= frac_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        rstat_reg <= rstat_next;
        ramp_reg  <= ramp_next;
        rfreq_reg <= rfreq_next;
        rbw_reg   <= rbw_next;
        rph_reg   <= rph_next;
        md_reg    <= md_next;
    end

endmodule

@@ hw/rtl/pfi_frame_mem.sv @@
// Frame store: one synchronous RAM of frames, one write and one registered read port.
`timescale 1ns / 1ps
module pfi_frame_mem #(
    parameter int DEPTH = pfi_pkg::DEF_MAX_PARTIALS * pfi_pkg::DEF_MAX_FRAMES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  pfi_pkg::frame_t wdata,
    input  logic [AW-1:0]   raddr,
    output pfi_pkg::frame_t rdata
);
    import pfi_pkg::*;

    frame_t mem [DEPTH];
    frame_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/pfi_part_mem.sv @@
// Per-partial frame count and time range: RAM with valid bits for the reset values.
`timescale 1ns / 1ps
module pfi_part_mem #(
    parameter int MAX_PARTIALS = pfi_pkg::DEF_MAX_PARTIALS,
    parameter int CW           = 9,
    parameter int PAW          = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           we,
    input  logic [PAW-1:0] waddr,
    input  logic [CW-1:0]  wcnt,
    input  logic [31:0]    wmin,
    input  logic [31:0]    wmax,
    input  logic [PAW-1:0] raddr,
    output logic [CW-1:0]  rcnt,
    output logic [31:0]    rmin,
    output logic [31:0]    rmax
);
    import pfi_pkg::*;

    logic [CW+63:0] mem [MAX_PARTIALS];
    logic [MAX_PARTIALS-1:0] valid_reg;
    logic [CW+63:0] rd_reg;
    logic rvld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rvld_reg  <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvld_reg <= valid_reg[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wcnt, wmin, wmax};
        end
        rd_reg <= mem[raddr];
    end

    assign rcnt = rvld_reg ? rd_reg[CW+63:64] : '0;
    assign rmin = rvld_reg ? rd_reg[63:32] : 32'hFFFF_FFFF;
    assign rmax = rvld_reg ? rd_reg[31:0] : 32'h0;

endmodule

@@ hw/rtl/pfi_div.sv @@
// Restoring divider: 16-bit fraction of num/den with num < den, one bit per cycle.
`timescale 1ns / 1ps
module pfi_div (
    input  logic              clk,
    input  logic              rst_n,
    input  pfi_pkg::div_req_t req,
    output pfi_pkg::div_rsp_t rsp
);
    import pfi_pkg::*;

    logic [32:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [33:0] shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, 1'b0};
        if (req.start)
        begin
            rem_next = {1'b0, req.num};
            den_next = req.den;
            quo_next = '0;
            cnt_next = 5'd16;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (shifted >= {2'b0, den_reg})
            begin
                rem_next = 33'(shifted - {2'b0, den_reg});
                quo_next = {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[32:0];
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

@@ hw/rtl/pfi_checker.sv @@
// Port-level checks of the partial frame interpolator, bound to the top level.
`timescale 1ns / 1ps
module pfi_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [87:0]  m_tdata
);
    import pfi_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == ST_OK || m_tdata[1:0] == ST_BAD_PART
                      || m_tdata[1:0] == ST_BAD_RANGE))
        else $error("undefined status code");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[87:2] == '0)
        else $error("error result carries data");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

endmodule

bind partial_frame_interpolator pfi_checker u_pfi_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

@@ tb/sv/partial_frame_interpolator_checker.sv @@
// Checker for the partial frame interpolator: watches both streams, predicts and compares.
`timescale 1ns / 1ps
module partial_frame_interpolator_checker
    import pfi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [6:0]   cfg_wr_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [87:0]  m_tdata,
    output int           errors,
    output int           pending
);

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        amp;
        logic [31:0]        freq;
        logic [15:0]        bw;
        logic signed [15:0] phase;
    } lookup_t;

    logic [31:0] tbl_time [0:16383];
    logic [15:0] tbl_amp  [0:16383];
    logic [31:0] tbl_freq [0:16383];
    logic [15:0] tbl_bw   [0:16383];
    logic [15:0] tbl_phase[0:16383];
    logic [8:0]  nframes  [0:63];
    logic [31:0] tmin     [0:63];
    logic [31:0] tmax     [0:63];
    logic [6:0]  live_partials;
    lookup_t     expected_lookups[$];

    function automatic logic [63:0] blend(logic [63:0] a, logic [63:0] b, logic [63:0] w);
        return (a * (64'd65536 - w) + b * w + 64'd32768) >> 16;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic lookup_t predict_lookup(logic [127:0] d);
        lookup_t r;
        logic [1:0]  op;
        logic [5:0]  p;
        logic [7:0]  f;
        logic [31:0] t, t1, t2;
        int base, i1, i2, sel;
        logic [63:0] w;
        longint d1, d2;
        op = d[1:0]; p = d[7:2]; f = d[15:8]; t = d[47:16];
        r = '0;
        base = int'(p) * 256;
        if (op == OP_WRITE) begin
            tbl_time[base + f]  = t;
            tbl_amp[base + f]   = d[63:48];
            tbl_freq[base + f]  = d[95:64];
            tbl_bw[base + f]    = d[111:96];
            tbl_phase[base + f] = d[127:112];
            if (nframes[p] < f + 9'd1) nframes[p] = f + 9'd1;
            if (t < tmin[p]) tmin[p] = t;
            if (t > tmax[p]) tmax[p] = t;
            return r;
        end
        if ({1'b0, p} >= live_partials) begin
            r.status = ST_BAD_PART;
            return r;
        end
        if (op == OP_INDEX) begin
            if ({1'b0, f} >= nframes[p]) begin
                r.status = ST_BAD_RANGE;
                return r;
            end
            sel = base + f;
        end else begin
            if (!(t >= tmin[p] && t < tmax[p])) begin
                r.status = ST_BAD_RANGE;
                return r;
            end
            i1 = 0; i2 = 1;
            for (int i = 1; i < nframes[p]; i++)
                if (t < tbl_time[base + i]) begin
                    i1 = i - 1; i2 = i;
                    break;
                end
            t1 = tbl_time[base + i1];
            t2 = tbl_time[base + i2];
            if (op == OP_NEAREST) begin
                d1 = longint'(t) - longint'(t1);
                d2 = longint'(t2) - longint'(t);
                sel = base + ((d1 < d2) ? i1 : i2);
            end else begin
                if (t2 <= t1 || t <= t1) w = 0;
                else if (t >= t2) w = 65536;
                else w = ({32'd0, t - t1} << 16) / {32'd0, t2 - t1};
                r.amp   = 16'(blend(tbl_amp[base + i1], tbl_amp[base + i2], w));
                r.freq  = 32'(blend(tbl_freq[base + i1], tbl_freq[base + i2], w));
                r.bw    = 16'(blend(tbl_bw[base + i1], tbl_bw[base + i2], w));
                r.phase = tbl_phase[base + i1];
                return r;
            end
        end
        r.amp = tbl_amp[sel]; r.freq = tbl_freq[sel];
        r.bw = tbl_bw[sel]; r.phase = tbl_phase[sel];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        lookup_t want;
        if (!rst_n) begin
            for (int p = 0; p < 64; p++) begin
                nframes[p] = 0; tmin[p] = '1; tmax[p] = 0;
            end
            live_partials = 0;
            errors = 0;
            expected_lookups.delete();
            pending = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_lookups.size() == 0)
                    report("unexpected item", 64'(m_tdata), 0);
                else begin
                    want = expected_lookups.pop_front();
                    if (m_tdata[1:0] != want.status)  report("status", m_tdata[1:0], want.status);
                    if (m_tdata[17:2] != want.amp)    report("amp", m_tdata[17:2], want.amp);
                    if (m_tdata[49:18] != want.freq)  report("freq", m_tdata[49:18], want.freq);
                    if (m_tdata[65:50] != want.bw)    report("bandwidth", m_tdata[65:50], want.bw);
                    if (m_tdata[81:66] != want.phase) report("phase", m_tdata[81:66], want.phase);
                end
            end
            if (s_tvalid && s_tready)
                expected_lookups = {expected_lookups, predict_lookup(s_tdata)};
            if (cfg_wr_en) live_partials = cfg_wr_data;
            pending = expected_lookups.size();
        end
    end

endmodule

@@ tb/sv/partial_frame_interpolator_tb.sv @@
// Testbench top of the partial frame interpolator: stimulus, idling and verdict.
`timescale 1ns / 1ps
module partial_frame_interpolator_tb;
    import pfi_pkg::*;

    logic         clk = 0;
    logic         rst_n = 0;
    logic         cfg_wr_en = 0;
    logic [6:0]   cfg_wr_data = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [127:0] s_tdata = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [87:0]  m_tdata;
    int           errors, pending;
    int           cycles = 0;
    int           burst_left = 0;
    int           stall_mode = 0;
    logic [8:0]   filled [0:63];
    logic [31:0]  tlo [0:63];
    logic [31:0]  thi [0:63];

    always #4 clk = ~clk;

    partial_frame_interpolator dut (.*);

    partial_frame_interpolator_checker chk (.*);

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("[partial_frame_interpolator] ERROR");
            $finish;
        end
    end

    // receiver stall pattern picks one of three modes at random: always ready, random or patterned
    always @(posedge clk) begin
        if (cycles % 512 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ((cycles / 5) % 3 != 0);
        endcase
    end

    task automatic send_item(logic [1:0] op, logic [5:0] p, logic [7:0] f, logic [31:0] t,
                             logic [15:0] amp, logic [31:0] freq, logic [15:0] bw,
                             logic [15:0] ph);
        if (burst_left == 0) begin
            repeat ($urandom_range(0, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {ph, bw, freq, amp, t, f, p, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (burst_left == 0) s_tvalid <= 1'b0;
    endtask

    task automatic send_write(logic [5:0] p, logic [7:0] f, logic [31:0] t);
        send_item(OP_WRITE, p, f, t, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic write_partial(logic [5:0] p, int n);
        logic [31:0] t;
        t = $urandom_range(0, 32'h00ffffff);
        for (int i = 0; i < n; i++) begin
            send_write(p, i, t);
            if (i == 0) tlo[p] = t;
            thi[p] = t;
            t = t + $urandom_range(0, 3) * $urandom_range(1, 32'h00100000);
        end
        if (n > filled[p]) filled[p] = n;
    endtask

    task automatic drain_and_config(logic [6:0] v);
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_query(int maxp);
        logic [5:0]  p;
        logic [1:0]  op;
        logic [31:0] t;
        p = $urandom_range(0, maxp);
        op = $urandom_range(1, 3);
        if (filled[p] == 0 || $urandom_range(0, 9) == 0) begin
            // partial/time/index mostly out of range, never reaching unwritten entries
            if (filled[p] == 0) p = $urandom_range(0, 63);
            if (filled[p] == 0) t = $urandom;
            else t = ($urandom_range(0, 1)) ? thi[p] + $urandom_range(0, 255) : $urandom;
            if (filled[p] == 0 || t < tlo[p] || t >= thi[p])
                send_item(op, p, filled[p] + $urandom_range(0, 255 - filled[p] % 256),
                          t, $urandom, $urandom, $urandom, $urandom);
            else
                send_item(OP_INDEX, p, $urandom_range(0, filled[p] - 1), t,
                          $urandom, $urandom, $urandom, $urandom);
        end else begin
            t = tlo[p] + $urandom_range(0, thi[p] - tlo[p]);
            send_item(op, p, $urandom_range(0, filled[p] - 1), t,
                      $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        logic [5:0] p;
        int n;
        for (int i = 0; i < 64; i++) filled[i] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: queries before config, extremes, ties
        send_item(OP_INTERP, 0, 0, 0, 0, 0, 0, 0);
        drain_and_config(7'd64);
        send_item(OP_INDEX, 63, 0, 0, 0, 0, 0, 0);
        send_item(OP_WRITE, 63, 255, '1, '1, '1, '1, 16'h8000);
        send_item(OP_WRITE, 63, 0, 0, 0, 0, 0, 16'h7fff);
        filled[63] = 256;
        for (int i = 1; i < 255; i++) send_item(OP_WRITE, 63, i, i * 1000, i, i, i, i);
        tlo[63] = 0; thi[63] = '1;
        send_item(OP_INDEX, 63, 255, 0, 0, 0, 0, 0);
        send_item(OP_INTERP, 63, 0, 32'hfffffffe, 0, 0, 0, 0);
        send_item(OP_NEAREST, 63, 0, 1500, 0, 0, 0, 0);
        send_item(OP_NEAREST, 63, 0, 1499, 0, 0, 0, 0);
        send_item(OP_INTERP, 63, 0, '1, 0, 0, 0, 0);
        send_item(OP_WRITE, 1, 0, 100, 10, 10, 10, 10);
        send_item(OP_WRITE, 1, 1, 100, 20, 20, 20, 20);
        send_item(OP_WRITE, 1, 2, 200, 30, 30, 30, 30);
        filled[1] = 3; tlo[1] = 100; thi[1] = 200;
        send_item(OP_INTERP, 1, 0, 100, 0, 0, 0, 0);
        send_item(OP_NEAREST, 1, 0, 150, 0, 0, 0, 0);
        send_item(OP_INDEX, 1, 3, 0, 0, 0, 0, 0);
        drain_and_config(7'd0);
        send_item(OP_NEAREST, 1, 0, 150, 0, 0, 0, 0);
        // random phases with different partial counts; every partial written gets two frames or more
        for (int ph = 0; ph < 6; ph++) begin
            drain_and_config(ph == 5 ? 7'd127 : 7'($urandom_range(1, 64)));
            for (int k = 0; k < 12; k++) begin
                p = $urandom_range(0, 62);
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 40) : $urandom_range(2, 8);
                write_partial(p, n);
            end
            for (int k = 0; k < 170; k++) random_query(ph < 2 ? 15 : 63);
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("[partial_frame_interpolator] OK");
        else
            $display("[partial_frame_interpolator] ERROR");
        $finish;
    end

endmodule
